@@ src/mtep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtep_pkg
// Types and codes shared by the MIDI track event parser: input and result
// item layouts and the record kind codes.
// ----------------------------------------------------------------------------
package mtep_pkg;

    // Record kind codes
    localparam logic [2:0] KIND_CHUNK_LEN = 3'd0;
    localparam logic [2:0] KIND_CHANNEL   = 3'd1;
    localparam logic [2:0] KIND_META      = 3'd2;
    localparam logic [2:0] KIND_TEXT      = 3'd3;
    localparam logic [2:0] KIND_SYSEX     = 3'd4;
    localparam logic [2:0] KIND_END_TRACK = 3'd5;
    localparam logic [2:0] KIND_OTHER     = 3'd6;

    // Status and meta codes
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0] META_END      = 8'h2F;
    localparam logic [7:0] META_SEQ_SPEC = 8'h7F;
    localparam logic [7:0] META_TEXT_LO  = 8'h01;
    localparam logic [7:0] META_TEXT_HI  = 8'h07;
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_PRESSURE   = 4'hD;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [2:0]  record_kind;
        logic [31:0] delta_time;
        logic [7:0]  status_value;
        logic [7:0]  first_data;
        logic [7:0]  second_data;
        logic [7:0]  meta_kind;
        logic [31:0] body_length;
        logic [31:0] payload_value;
        logic        text_last;
    } t_out_item;

endpackage

@@ src/midi_track_event_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_track_event_parser
// Parses a MIDI track chunk one byte per item: chunk length, then events
// (varlen delta, status, body), a record per length, event or text byte.
// ----------------------------------------------------------------------------
// A result appears in the output register in the cycle after the byte
// that completes it is accepted.
// Throughput: one byte per cycle unless stalled; single-pass state update.
// A result held in the output register under output stall stalls the input.
// Reset: synchronous, active low; parser returns to the chunk length phase.
// A byte with track_start set restarts the parser on that same byte.
module midi_track_event_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mtep_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mtep_pkg::t_out_item  o_out_data
);
    import mtep_pkg::*;

    typedef enum logic [10:0] {
        PH_LEN    = 11'b000_0000_0001,
        PH_DELTA  = 11'b000_0000_0010,
        PH_STATUS = 11'b000_0000_0100,
        PH_CH1    = 11'b000_0000_1000,
        PH_CH2    = 11'b000_0001_0000,
        PH_MTYPE  = 11'b000_0010_0000,
        PH_MVLEN  = 11'b000_0100_0000,
        PH_MBLEN  = 11'b000_1000_0000,
        PH_BODY   = 11'b001_0000_0000,
        PH_SVLEN  = 11'b010_0000_0000,
        PH_ENDED  = 11'b100_0000_0000
    } t_phase;

    function automatic logic is_text(input logic [7:0] t);
        is_text = (t >= META_TEXT_LO) && (t <= META_TEXT_HI);
    endfunction

    // Parse state
    t_phase      r_phase,  n_phase;
    logic [1:0]  r_cnt,    n_cnt;
    logic [31:0] r_delta,  n_delta;
    logic [7:0]  r_status, n_status;
    logic [7:0]  r_data,   n_data;
    logic [7:0]  r_meta,   n_meta;
    logic [31:0] r_rem,    n_rem;
    logic [31:0] r_len,    n_len;
    logic [31:0] r_pay,    n_pay;

    // Output register
    logic        r_out_valid;
    t_out_item   r_out;

    // State as seen by this byte (track_start restarts first)
    t_phase      e_phase;
    logic [1:0]  e_cnt;
    logic [31:0] e_delta;
    logic [7:0]  e_status;
    logic [7:0]  e_data;
    logic [7:0]  e_meta;
    logic [31:0] e_rem;
    logic [31:0] e_len;
    logic [31:0] e_pay;

    logic        in_acc;
    logic        res_valid;
    t_out_item   res;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        if (i_in_data.track_start) begin
            e_phase  = PH_LEN;
            e_cnt    = 2'd0;
            e_delta  = '0;
            e_status = '0;
            e_data   = '0;
            e_meta   = '0;
            e_rem    = '0;
            e_len    = '0;
            e_pay    = '0;
        end else begin
            e_phase  = r_phase;
            e_cnt    = r_cnt;
            e_delta  = r_delta;
            e_status = r_status;
            e_data   = r_data;
            e_meta   = r_meta;
            e_rem    = r_rem;
            e_len    = r_len;
            e_pay    = r_pay;
        end
    end

    // Single-pass next state and result
    always_comb begin
        logic [7:0]  b;
        logic [31:0] len_v;
        logic [31:0] rem_v;
        logic [31:0] fin_pay;
        logic        do_len;
        logic        do_finish;
        logic        do_next;

        b         = i_in_data.data_byte;
        len_v     = '0;
        rem_v     = e_rem - 32'd1;
        fin_pay   = e_pay;
        do_len    = 1'b0;
        do_finish = 1'b0;
        do_next   = 1'b0;

        n_phase   = e_phase;
        n_cnt     = e_cnt;
        n_delta   = e_delta;
        n_status  = e_status;
        n_data    = e_data;
        n_meta    = e_meta;
        n_rem     = e_rem;
        n_len     = e_len;
        n_pay     = e_pay;
        res_valid = 1'b0;
        res       = '0;

        case (e_phase)
            PH_LEN: begin
                n_pay = {e_pay[23:0], b};
                if (e_cnt == 2'd3) begin
                    res_valid         = 1'b1;
                    res.record_kind   = KIND_CHUNK_LEN;
                    res.payload_value = {e_pay[23:0], b};
                    n_cnt             = 2'd0;
                    do_next           = 1'b1;
                end else begin
                    n_cnt = e_cnt + 2'd1;
                end
            end
            PH_DELTA: begin
                n_delta = {e_delta[24:0], b[6:0]};
                if (!b[7]) begin
                    n_phase = PH_STATUS;
                end
            end
            PH_STATUS: begin
                n_status = b;
                n_data   = '0;
                n_meta   = '0;
                n_len    = '0;
                n_rem    = '0;
                n_pay    = '0;
                if (b[7:4] >= HI_NOTE_OFF && b[7:4] <= HI_PITCH_BEND) begin
                    n_phase = PH_CH1;
                end else if (b == STATUS_META) begin
                    n_phase = PH_MTYPE;
                end else if (b == STATUS_SYSEX) begin
                    n_phase = PH_SVLEN;
                end else begin
                    res_valid        = 1'b1;
                    res.record_kind  = KIND_OTHER;
                    res.delta_time   = e_delta;
                    res.status_value = b;
                    do_next          = 1'b1;
                end
            end
            PH_CH1: begin
                n_data = b;
                if (e_status[7:4] == HI_PROGRAM || e_status[7:4] == HI_PRESSURE) begin
                    res_valid        = 1'b1;
                    res.record_kind  = KIND_CHANNEL;
                    res.delta_time   = e_delta;
                    res.status_value = e_status;
                    res.first_data   = b;
                    do_next          = 1'b1;
                end else begin
                    n_phase = PH_CH2;
                end
            end
            PH_CH2: begin
                res_valid        = 1'b1;
                res.record_kind  = KIND_CHANNEL;
                res.delta_time   = e_delta;
                res.status_value = e_status;
                res.first_data   = e_data;
                res.second_data  = b;
                do_next          = 1'b1;
            end
            PH_MTYPE: begin
                n_meta  = b;
                n_phase = (is_text(b) || b == META_SEQ_SPEC) ? PH_MVLEN : PH_MBLEN;
            end
            PH_MVLEN, PH_SVLEN: begin
                len_v = {e_len[24:0], b[6:0]};
                n_len = len_v;
                do_len = !b[7];
            end
            PH_MBLEN: begin
                len_v  = {24'd0, b};
                n_len  = len_v;
                do_len = 1'b1;
            end
            PH_BODY: begin
                n_rem = rem_v;
                if (e_status == STATUS_META && is_text(e_meta)) begin
                    res_valid        = 1'b1;
                    res.record_kind  = KIND_TEXT;
                    res.delta_time   = e_delta;
                    res.status_value = STATUS_META;
                    res.first_data   = b;
                    res.meta_kind    = e_meta;
                    res.body_length  = e_len;
                    res.text_last    = (rem_v == 32'd0);
                    do_next          = (rem_v == 32'd0);
                end else begin
                    fin_pay   = {e_pay[23:0], b};
                    n_pay     = fin_pay;
                    do_finish = (rem_v == 32'd0);
                end
            end
            default: begin
                // track ended: bytes ignored until restart
            end
        endcase

        // Length complete: empty payload finishes at once
        if (do_len) begin
            n_rem = len_v;
            if (len_v == 32'd0) begin
                do_finish = 1'b1;
            end else begin
                n_phase = PH_BODY;
            end
        end

        // Meta or sysex payload complete
        if (do_finish) begin
            res_valid         = 1'b1;
            res.delta_time    = e_delta;
            res.status_value  = e_status;
            res.body_length   = n_len;
            res.payload_value = fin_pay;
            if (e_status == STATUS_META) begin
                res.meta_kind = e_meta;
                if (e_meta == META_END) begin
                    res.record_kind = KIND_END_TRACK;
                    n_phase         = PH_ENDED;
                end else begin
                    res.record_kind = KIND_META;
                    do_next         = 1'b1;
                end
            end else begin
                res.record_kind = KIND_SYSEX;
                do_next         = 1'b1;
            end
        end

        // Start of next event
        if (do_next) begin
            n_delta = '0;
            n_pay   = '0;
            n_phase = PH_DELTA;
        end
    end

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN;
            r_cnt    <= 2'd0;
            r_delta  <= '0;
            r_status <= '0;
            r_data   <= '0;
            r_meta   <= '0;
            r_rem    <= '0;
            r_len    <= '0;
            r_pay    <= '0;
        end else if (in_acc) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_delta  <= n_delta;
            r_status <= n_status;
            r_data   <= n_data;
            r_meta   <= n_meta;
            r_rem    <= n_rem;
            r_len    <= n_len;
            r_pay    <= n_pay;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= res_valid;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && res_valid) begin
            r_out <= res;
        end
    end

endmodule
